// ----- design/heightfield_height_query_assert.svh -----
// Assertion macros shared by the height query RTL.
// Each macro expands to one labeled concurrent assertion that is disabled during reset.
// No other file is needed.
`ifndef HEIGHTFIELD_HEIGHT_QUERY_ASSERT_SVH
`define HEIGHTFIELD_HEIGHT_QUERY_ASSERT_SVH

// The consequence must hold in the same cycle as the trigger.
`define HFQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the trigger.
`define HFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// The consequence must hold after the delay dly, counted from the trigger.
`define HFQ_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ----- design/hfq_pkg.sv -----
// Shared constants, codes and helper functions for the heightfield height query.
// Used by the top level; depends on nothing else.
package hfq_pkg;

    // Grid geometry and height memory.
    localparam int MAX_SIDE    = 129;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SIDE_W      = $clog2(MAX_SIDE + 1);

    // Field widths of the streams and the register file.
    localparam int CFG_SIDE_W = 8;
    localparam int POS_W      = 24;
    localparam int INV_W      = 24;
    localparam int VIDX_W     = 15;
    localparam int HEIGHT_W   = 16;
    localparam int IN_FIELD_W = 2 * POS_W + VIDX_W + HEIGHT_W;
    localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    // Fixed-point formats of the cell coordinates and the interpolation.
    localparam int FRAC_W  = 24;
    localparam int PROD_W  = POS_W + INV_W;
    localparam int CELL_W  = PROD_W + 1;
    localparam int COORD_W = CELL_W - FRAC_W;
    localparam int WGT_W   = FRAC_W + 1;
    localparam int DIFF_W  = HEIGHT_W + 1;
    localparam int TERM_W  = DIFF_W + WGT_W;
    localparam int SUM_W   = TERM_W + 2;
    localparam int HEXT_W  = SUM_W - FRAC_W;

    localparam logic [WGT_W-1:0] ONE_FX = {1'b1, {FRAC_W{1'b0}}};

    // Output queue; the depth must be a power of two.
    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    // Item kinds carried in the input tuser bit.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_COLS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_ROWS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_CELL  = 2'd2;

    // Reset values of the registers.
    localparam logic [CFG_SIDE_W-1:0] SIDE_RST     = 8'd129;
    localparam logic [INV_W-1:0]      INV_CELL_RST = 24'd65536;

    // Grid side as written, limited to the range the memory supports.
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_SIDE_W-1:0] v);
        logic [SIDE_W-1:0] res;
        if (32'(v) < 32'd2) begin
            res = SIDE_W'(2);
        end else if (32'(v) > 32'(MAX_SIDE)) begin
            res = SIDE_W'(MAX_SIDE);
        end else begin
            res = SIDE_W'(v);
        end
        return res;
    endfunction

endpackage

// ----- design/heightfield_height_query.sv -----
// Top level of the heightfield height query: position mapping, memory sequencer,
// triangle interpolation and output queue. Depends on hfq_pkg, hfq_ram and the
// assertion macro header.
//
//  Channel   Direction  Transfer rule                    Contents
//  s_axis    in         tvalid & tready                  tuser: mode; tdata: position, vertex
//  m_axis    out        tvalid & tready                  tuser: clamped; tdata: height
//  cfg       in         i_cfg_we                         register index and write data
//
// An in-range vertex write takes a single access of the single-port height memory; a query reads
// its four corner heights from that port one after another, and the next item waits until the
// last corner read is issued. Writes are accepted one per cycle while the pipeline does not stall.
// The height memory is not cleared by reset; every corner that a query touches must have
// been written first. Reset clears the pipeline and the output queue and resets the registers.
// When m_axis stalls, up to four results wait in the output queue; further queries then
// hold in the sequencer and the input side backs up behind them.

`include "heightfield_height_query_assert.svh"

module heightfield_height_query
    import hfq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x[23:0], pos_z[47:24], vertex_index[62:48], vertex_height[78:63], zero[79]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // height[15:0]
    output logic [HEIGHT_W-1:0]   m_axis_tdata,
    // clamped[0]
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Corner order of the four reads of a query.
    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;
    localparam logic [1:0] CORNER_D = 2'd3;

    localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [HEXT_W-1:0] SAT_HI = HEXT_W'((1 <<< (HEIGHT_W - 1)) - 1);
    localparam logic signed [HEXT_W-1:0] SAT_LO = HEXT_W'(-(1 <<< (HEIGHT_W - 1)));

    // Fields that every item carries to the memory port.
    typedef struct packed {
        logic                       mode;
        logic [VIDX_W-1:0]          index;
        logic signed [HEIGHT_W-1:0] height;
    } t_fwd;

    // One axis of a position mapped onto the grid.
    typedef struct packed {
        logic [SIDE_W-1:0] idx;
        logic [WGT_W-1:0]  off;
        logic              clamped;
    } t_axis;

    typedef struct packed {
        logic                       clamped;
        logic signed [HEIGHT_W-1:0] height;
    } t_result;

    // Floor a cell coordinate, clamp the cell to the grid and the offset to 0..1.
    function automatic t_axis split_axis(input logic signed [CELL_W-1:0] c,
                                         input logic [SIDE_W-1:0] side);
        logic signed [COORD_W-1:0] whole;
        logic [FRAC_W-1:0]         frac;
        logic signed [COORD_W-1:0] top_cell;
        logic signed [COORD_W-1:0] top_edge;
        logic                      neg;
        logic                      over;
        t_axis                     res;
        whole    = c[CELL_W-1:FRAC_W];
        frac     = c[FRAC_W-1:0];
        top_cell = $signed(COORD_W'(side - SIDE_W'(2)));
        top_edge = $signed(COORD_W'(side - SIDE_W'(1)));
        neg      = whole[COORD_W-1];
        over     = whole > top_cell;
        res.idx  = neg ? '0 : (over ? top_cell[SIDE_W-1:0] : whole[SIDE_W-1:0]);
        res.off  = neg ? '0 : (over ? ONE_FX : {1'b0, frac});
        res.clamped = neg || (whole > top_edge) || ((whole == top_edge) && (frac != '0));
        return res;
    endfunction

    // Configuration registers; the grid sides are stored already clamped.
    logic [SIDE_W-1:0] r_cols;
    logic [SIDE_W-1:0] r_rows;
    logic [INV_W-1:0]  r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= clamp_side(SIDE_RST);
            r_rows <= clamp_side(SIDE_RST);
            r_inv  <= INV_CELL_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_GRID_COLS) begin
                r_cols <= clamp_side(i_cfg_wdata[CFG_SIDE_W-1:0]);
            end
            if (i_cfg_addr == CFG_GRID_ROWS) begin
                r_rows <= clamp_side(i_cfg_wdata[CFG_SIDE_W-1:0]);
            end
            if (i_cfg_addr == CFG_INV_CELL) begin
                r_inv <= i_cfg_wdata[INV_W-1:0];
            end
        end
    end

    // Input fields.
    logic signed [POS_W-1:0] in_pos_x;
    logic signed [POS_W-1:0] in_pos_z;
    t_fwd                    in_fwd;

    assign in_pos_x      = s_axis_tdata[POS_W-1:0];
    assign in_pos_z      = s_axis_tdata[2*POS_W-1:POS_W];
    assign in_fwd.mode   = s_axis_tuser;
    assign in_fwd.index  = s_axis_tdata[2*POS_W+VIDX_W-1:2*POS_W];
    assign in_fwd.height = s_axis_tdata[IN_FIELD_W-1:2*POS_W+VIDX_W];

    // Pipeline control: each stage loads when it is empty or its item moves on.
    logic r_b_valid, r_c_valid, r_d_valid, r_s_valid;
    logic b_ready, c_ready, d_ready, s_ready;
    logic s_done;

    assign s_ready       = !r_s_valid || s_done;
    assign d_ready       = !r_d_valid || s_ready;
    assign c_ready       = !r_c_valid || d_ready;
    assign b_ready       = !r_b_valid || c_ready;
    assign s_axis_tready = b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (b_ready) begin
                r_b_valid <= s_axis_tvalid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
            if (d_ready) begin
                r_d_valid <= r_c_valid;
            end
            if (s_ready) begin
                r_s_valid <= r_d_valid;
            end
        end
    end

    // Stage B: scale both coordinates by the reciprocal cell size.
    logic signed [INV_W:0]    inv_s;
    logic signed [PROD_W-1:0] n_b_prod_x, n_b_prod_z;
    logic signed [PROD_W-1:0] r_b_prod_x, r_b_prod_z;
    t_fwd                     r_b_fwd;

    assign inv_s      = {1'b0, r_inv};
    assign n_b_prod_x = in_pos_x * inv_s;
    assign n_b_prod_z = in_pos_z * inv_s;

    always_ff @(posedge i_clk) begin
        if (b_ready) begin
            r_b_prod_x <= n_b_prod_x;
            r_b_prod_z <= n_b_prod_z;
            r_b_fwd    <= in_fwd;
        end
    end

    // Stage C: center on the grid; z runs toward lower rows.
    logic [SIDE_W+FRAC_W-2:0] half_x, half_z;
    logic signed [CELL_W-1:0] n_c_cx, n_c_cz;
    logic signed [CELL_W-1:0] r_c_cx, r_c_cz;
    t_fwd                     r_c_fwd;

    assign half_x = {r_cols - SIDE_W'(1), {(FRAC_W - 1){1'b0}}};
    assign half_z = {r_rows - SIDE_W'(1), {(FRAC_W - 1){1'b0}}};
    assign n_c_cx = $signed(CELL_W'(half_x)) + CELL_W'(r_b_prod_x);
    assign n_c_cz = $signed(CELL_W'(half_z)) - CELL_W'(r_b_prod_z);

    always_ff @(posedge i_clk) begin
        if (c_ready) begin
            r_c_cx  <= n_c_cx;
            r_c_cz  <= n_c_cz;
            r_c_fwd <= r_b_fwd;
        end
    end

    // Stage D: cell indexes, offsets and the outside-grid flag.
    t_axis n_d_x, n_d_z;
    t_axis r_d_x, r_d_z;
    t_fwd  r_d_fwd;

    assign n_d_x = split_axis(r_c_cx, r_cols);
    assign n_d_z = split_axis(r_c_cz, r_rows);

    always_ff @(posedge i_clk) begin
        if (d_ready) begin
            r_d_x   <= n_d_x;
            r_d_z   <= n_d_z;
            r_d_fwd <= r_c_fwd;
        end
    end

    // Sequencer load: base address, triangle choice and weights.
    logic [2*SIDE_W-1:0] row_base;
    logic [2*SIDE_W-1:0] base_full;
    logic [WGT_W:0]      off_sum;
    logic                n_s_tri;
    logic [WGT_W-1:0]    n_s_w1, n_s_w2;

    assign row_base  = r_d_z.idx * r_cols;
    assign base_full = row_base + (2 * SIDE_W)'(r_d_x.idx);
    assign off_sum   = (WGT_W + 1)'(r_d_x.off) + (WGT_W + 1)'(r_d_z.off);
    assign n_s_tri   = off_sum < (WGT_W + 1)'(ONE_FX);
    assign n_s_w1    = n_s_tri ? r_d_x.off : ONE_FX - r_d_x.off;
    assign n_s_w2    = n_s_tri ? r_d_z.off : ONE_FX - r_d_z.off;

    logic [ADDR_W-1:0] r_s_base;
    logic              r_s_tri;
    logic [WGT_W-1:0]  r_s_w1, r_s_w2;
    logic              r_s_clamped;
    t_fwd              r_s_fwd;
    logic [1:0]        r_s_cnt;

    always_ff @(posedge i_clk) begin
        if (s_ready) begin
            r_s_base    <= ADDR_W'(base_full);
            r_s_tri     <= n_s_tri;
            r_s_w1      <= n_s_w1;
            r_s_w2      <= n_s_w2;
            r_s_clamped <= r_d_x.clamped || r_d_z.clamped;
            r_s_fwd     <= r_d_fwd;
        end
    end

    // Memory sequencer: one access for an in-range write, four corner reads for a query.
    // A query starts only while the output queue has room for its result.
    logic [CNT_W-1:0]  r_credit;
    logic              s_is_query;
    logic              credit_ok;
    logic              s_fire;
    logic              q_start;
    logic              wr_in_range;
    logic [ADDR_W-1:0] corner_off;
    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic signed [HEIGHT_W-1:0] mem_rdata;

    assign s_is_query  = r_s_fwd.mode == MODE_QUERY;
    assign credit_ok   = r_credit < CNT_W'(OUT_DEPTH);
    assign s_fire      = r_s_valid && (!s_is_query || (r_s_cnt != CORNER_A) || credit_ok);
    assign s_done      = s_fire && (!s_is_query || (r_s_cnt == CORNER_D));
    assign q_start     = s_fire && s_is_query && (r_s_cnt == CORNER_A);
    assign wr_in_range = 32'(r_s_fwd.index) < 32'(STORE_DEPTH);

    always_comb begin
        unique case (r_s_cnt)
            CORNER_A: corner_off = '0;
            CORNER_B: corner_off = ADDR_W'(1);
            CORNER_C: corner_off = ADDR_W'(r_cols);
            CORNER_D: corner_off = ADDR_W'(r_cols) + ADDR_W'(1);
            default:  corner_off = '0;
        endcase
    end

    assign mem_en   = s_fire && (s_is_query || wr_in_range);
    assign mem_we   = !s_is_query;
    assign mem_addr = s_is_query ? r_s_base + corner_off : ADDR_W'(r_s_fwd.index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_cnt <= CORNER_A;
        end else if (s_fire && s_is_query) begin
            r_s_cnt <= r_s_cnt + 2'd1;
        end
    end

    hfq_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (STORE_DEPTH)
    ) u_height_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (r_s_fwd.height),
        .o_rdata (mem_rdata)
    );

    // Read tag: which corner returns this cycle, with the query's weights.
    logic             r_rt_valid;
    logic [1:0]       r_rt_sel;
    logic             r_rt_tri;
    logic [WGT_W-1:0] r_rt_w1, r_rt_w2;
    logic             r_rt_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_valid <= 1'b0;
        end else begin
            r_rt_valid <= s_fire && s_is_query;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rt_sel     <= r_s_cnt;
        r_rt_tri     <= r_s_tri;
        r_rt_w1      <= r_s_w1;
        r_rt_w2      <= r_s_w2;
        r_rt_clamped <= r_s_clamped;
    end

    // Corner capture; the last corner is used straight from the memory.
    logic signed [HEIGHT_W-1:0] r_ca, r_cb, r_cc;

    always_ff @(posedge i_clk) begin
        if (r_rt_valid && (r_rt_sel == CORNER_A)) begin
            r_ca <= mem_rdata;
        end
        if (r_rt_valid && (r_rt_sel == CORNER_B)) begin
            r_cb <= mem_rdata;
        end
        if (r_rt_valid && (r_rt_sel == CORNER_C)) begin
            r_cc <= mem_rdata;
        end
    end

    // Stage F: pick the triangle's anchor corner and the height differences along both of its edges.
    logic                       f_load;
    logic signed [HEIGHT_W-1:0] n_f_base;
    logic signed [DIFF_W-1:0]   n_f_e1, n_f_e2;
    logic                       r_f_valid;
    logic signed [HEIGHT_W-1:0] r_f_base;
    logic signed [DIFF_W-1:0]   r_f_e1, r_f_e2;
    logic [WGT_W-1:0]           r_f_w1, r_f_w2;
    logic                       r_f_clamped;

    assign f_load = r_rt_valid && (r_rt_sel == CORNER_D);

    always_comb begin
        if (r_rt_tri) begin
            n_f_base = r_ca;
            n_f_e1   = DIFF_W'(r_cb) - DIFF_W'(r_ca);
            n_f_e2   = DIFF_W'(r_cc) - DIFF_W'(r_ca);
        end else begin
            n_f_base = mem_rdata;
            n_f_e1   = DIFF_W'(r_cc) - DIFF_W'(mem_rdata);
            n_f_e2   = DIFF_W'(r_cb) - DIFF_W'(mem_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= f_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_base    <= n_f_base;
        r_f_e1      <= n_f_e1;
        r_f_e2      <= n_f_e2;
        r_f_w1      <= r_rt_w1;
        r_f_w2      <= r_rt_w2;
        r_f_clamped <= r_rt_clamped;
    end

    // Stage G: weight both edge differences.
    logic signed [WGT_W:0]      f_w1_s, f_w2_s;
    logic signed [TERM_W-1:0]   n_g_p1, n_g_p2;
    logic                       r_g_valid;
    logic signed [TERM_W-1:0]   r_g_p1, r_g_p2;
    logic signed [HEIGHT_W-1:0] r_g_base;
    logic                       r_g_clamped;

    assign f_w1_s = {1'b0, r_f_w1};
    assign f_w2_s = {1'b0, r_f_w2};
    assign n_g_p1 = r_f_e1 * f_w1_s;
    assign n_g_p2 = r_f_e2 * f_w2_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else begin
            r_g_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_p1      <= n_g_p1;
        r_g_p2      <= n_g_p2;
        r_g_base    <= r_f_base;
        r_g_clamped <= r_f_clamped;
    end

    // Final sum, round half up, saturate to the height format.
    logic signed [SUM_W-1:0]  h_sum;
    logic signed [HEXT_W-1:0] h_wide;
    t_result                  h_res;

    assign h_sum  = (SUM_W'(r_g_base) <<< FRAC_W) + SUM_W'(r_g_p1) + SUM_W'(r_g_p2)
                  + ROUND_HALF;
    assign h_wide = h_sum[SUM_W-1:FRAC_W];

    always_comb begin
        h_res.clamped = r_g_clamped;
        priority if (h_wide > SAT_HI) begin
            h_res.height = SAT_HI[HEIGHT_W-1:0];
        end else if (h_wide < SAT_LO) begin
            h_res.height = SAT_LO[HEIGHT_W-1:0];
        end else begin
            h_res.height = h_wide[HEIGHT_W-1:0];
        end
    end

    // Output queue and the count of queries that hold a place in it.
    t_result          r_fifo [OUT_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_fifo_cnt;
    logic             push, pop;

    assign push          = r_g_valid;
    assign m_axis_tvalid = r_fifo_cnt != '0;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = r_fifo[r_rd_ptr].height;
    assign m_axis_tuser  = r_fifo[r_rd_ptr].clamped;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= h_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_credit   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + CNT_W'(push) - CNT_W'(pop);
            r_credit   <= r_credit + CNT_W'(q_start) - CNT_W'(pop);
        end
    end

    // Checks on the sequencer, the result path and the queue accounting.
    `HFQ_ASSERT_IMPLY(a_credit_bound, i_clk, i_rst_n, 1'b1,
        r_credit <= CNT_W'(OUT_DEPTH), "queries in flight exceed the output queue depth")
    `HFQ_ASSERT_IMPLY(a_queue_within_credit, i_clk, i_rst_n, 1'b1,
        r_fifo_cnt <= r_credit, "output queue holds a result without a query in flight")
    `HFQ_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, push,
        (r_fifo_cnt != CNT_W'(OUT_DEPTH)) || pop, "result pushed into a full output queue")
    `HFQ_ASSERT_NEXT(a_query_continues, i_clk, i_rst_n, q_start,
        r_s_valid && (r_s_cnt == CORNER_B), "query did not continue with its second corner")
    `HFQ_ASSERT_DELAY(a_result_latency, i_clk, i_rst_n, f_load, 2,
        r_g_valid, "last corner read did not produce a result two cycles later")

endmodule

// ----- design/hfq_ram.sv -----
// Generic single-port synchronous RAM with a registered read port.
// Stand-alone; no package needed.
module hfq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: either a write or a read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sim/heightfield_height_query_checker.sv -----
// Checker for the heightfield height query: watches the input, output and register channels,
// predicts each query's height and clamp flag and compares them with the results.
// Depends on hfq_pkg for widths, item kinds and register indexes.
module heightfield_height_query_checker
    import hfq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // pos_x[23:0], pos_z[47:24], vertex_index[62:48], vertex_height[78:63], zero[79]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // height[15:0]
    input  logic [HEIGHT_W-1:0]   m_axis_tdata,
    // clamped[0]
    input  logic                  m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_item_count,
    output int                    o_query_count,
    output int                    o_clamp_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint FX_ONE = longint'(1) << FRAC_W;
    localparam longint H_MAX  = (longint'(1) << (HEIGHT_W - 1)) - 1;
    localparam longint H_MIN  = -(longint'(1) << (HEIGHT_W - 1));

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                clamped;
    } query_result_t;

    // Shadow copy of the vertex heights and of the register file.
    logic signed [HEIGHT_W-1:0] height_mem [STORE_DEPTH];
    logic [CFG_SIDE_W-1:0]      cols_reg;
    logic [CFG_SIDE_W-1:0]      rows_reg;
    logic [INV_W-1:0]           inv_reg;

    // Heights of queries that have been accepted but not yet answered, oldest first.
    query_result_t pending_heights [$];

    int fail_count  = 0;
    int item_count  = 0;
    int query_count = 0;
    int clamp_count = 0;

    // Grid side as the block uses it.
    function automatic longint side_limit(input logic [CFG_SIDE_W-1:0] v);
        longint s;
        s = longint'(v);
        if (s < 2) s = 2;
        if (s > MAX_SIDE) s = MAX_SIDE;
        return s;
    endfunction

    function automatic longint corner_height(input longint row, input longint col,
                                             input longint cols);
        return longint'(height_mem[int'(row * cols + col)]);
    endfunction

    // Map the position to a cell, clamp it, and interpolate on the chosen triangle.
    function automatic query_result_t interpolate_height(input logic signed [POS_W-1:0] px,
                                                         input logic signed [POS_W-1:0] pz);
        longint cols, rows, inv, cx, cz, col, row, dx, dz;
        longint ha, hb, hc, hd, acc, h;
        query_result_t r;
        cols = side_limit(cols_reg);
        rows = side_limit(rows_reg);
        inv  = longint'(inv_reg);
        cx = (cols - 1) * (FX_ONE / 2) + longint'(px) * inv;
        cz = (rows - 1) * (FX_ONE / 2) - longint'(pz) * inv;
        r.clamped = (cx < 0) || (cx > (cols - 1) * FX_ONE) ||
                    (cz < 0) || (cz > (rows - 1) * FX_ONE);
        col = cx >>> FRAC_W;
        row = cz >>> FRAC_W;
        if (col < 0) col = 0;
        if (row < 0) row = 0;
        if (col > cols - 2) col = cols - 2;
        if (row > rows - 2) row = rows - 2;
        dx = cx - col * FX_ONE;
        dz = cz - row * FX_ONE;
        if (dx < 0) dx = 0;
        if (dx > FX_ONE) dx = FX_ONE;
        if (dz < 0) dz = 0;
        if (dz > FX_ONE) dz = FX_ONE;
        ha = corner_height(row, col, cols);
        hb = corner_height(row, col + 1, cols);
        hc = corner_height(row + 1, col, cols);
        hd = corner_height(row + 1, col + 1, cols);
        // Upper-left triangle when below the diagonal, lower-right one otherwise.
        if (dz < FX_ONE - dx) begin
            acc = ha * FX_ONE + (hb - ha) * dx + (hc - ha) * dz;
        end else begin
            acc = hd * FX_ONE + (hc - hd) * (FX_ONE - dx) + (hb - hd) * (FX_ONE - dz);
        end
        h = (acc + FX_ONE / 2) >>> FRAC_W;
        if (h > H_MAX) h = H_MAX;
        if (h < H_MIN) h = H_MIN;
        r.height = HEIGHT_W'(h);
        return r;
    endfunction

    // Compare results first, then predict new transactions, then track register writes.
    always @(posedge i_clk) begin : monitor
        query_result_t       want;
        logic [VIDX_W-1:0]   vidx;
        if (!i_rst_n) begin
            cols_reg <= SIDE_RST;
            rows_reg <= SIDE_RST;
            inv_reg  <= INV_CELL_RST;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_heights.size() == 0) begin
                    $error("unexpected result: height %0d, clamped %0d",
                           $signed(m_axis_tdata), m_axis_tuser);
                    fail_count++;
                end else begin
                    want = pending_heights.pop_front();
                    if (m_axis_tdata !== want.height) begin
                        $error("height mismatch: expected %0d, actual %0d",
                               $signed(want.height), $signed(m_axis_tdata));
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.clamped) begin
                        $error("clamped mismatch: expected %0d, actual %0d",
                               want.clamped, m_axis_tuser);
                        fail_count++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                item_count++;
                if (s_axis_tuser == MODE_WRITE) begin
                    vidx = s_axis_tdata[2*POS_W +: VIDX_W];
                    if (int'(vidx) < STORE_DEPTH) begin
                        height_mem[vidx] = s_axis_tdata[2*POS_W+VIDX_W +: HEIGHT_W];
                    end
                end else begin
                    want = interpolate_height(s_axis_tdata[0 +: POS_W],
                                              s_axis_tdata[POS_W +: POS_W]);
                    query_count++;
                    if (want.clamped) clamp_count++;
                    pending_heights.push_back(want);
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_GRID_COLS: cols_reg <= i_cfg_wdata[CFG_SIDE_W-1:0];
                    CFG_GRID_ROWS: rows_reg <= i_cfg_wdata[CFG_SIDE_W-1:0];
                    CFG_INV_CELL:  inv_reg  <= i_cfg_wdata[INV_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count  <= fail_count;
        o_pending     <= pending_heights.size();
        o_item_count  <= item_count;
        o_query_count <= query_count;
        o_clamp_count <= clamp_count;
    end

endmodule

// ----- sim/heightfield_height_query_tb.sv -----
// Testbench top for the heightfield height query: clock, reset, register programming,
// stream stimulus with random back-pressure, and the verdict.
// Depends on hfq_pkg, the block itself and heightfield_height_query_checker.
module heightfield_height_query_tb;
    import hfq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index that the block does not implement.
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int PHASES          = 6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [HEIGHT_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int fail_count;
    int pending;
    int item_count;
    int query_count;
    int clamp_count;

    // Idle percentages of the two sides, and the grid as the block currently sees it.
    int     tx_idle_pct = 37;
    int     rx_idle_pct = 46;
    int     cur_cols = MAX_SIDE;
    int     cur_rows = MAX_SIDE;
    longint cur_inv = longint'(INV_CELL_RST);

    always #5 i_clk = ~i_clk;

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    heightfield_height_query i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    heightfield_height_query_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_item_count  (item_count),
        .o_query_count (query_count),
        .o_clamp_count (clamp_count)
    );

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Present one input transaction and hold it until it is taken.
    task automatic send_item(input logic mode, input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] pz, input logic [VIDX_W-1:0] vidx,
                             input logic [HEIGHT_W-1:0] vh);
        while (chance(tx_idle_pct)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, vh, vidx, pz, px};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Queries leave the unused write fields random.
    task automatic send_query(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
        send_item(MODE_QUERY, px, pz, VIDX_W'($urandom), HEIGHT_W'($urandom));
    endtask

    // Wait until every query has been answered, then let the pipeline run dry.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (30) @(posedge i_clk);
    endtask

    // Write the three grid registers back to back, optionally touching the unused index.
    task automatic program_grid(input logic [CFG_SIDE_W-1:0] cols,
                                input logic [CFG_SIDE_W-1:0] rows,
                                input logic [INV_W-1:0] inv, input bit touch_unused);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_GRID_COLS;
        i_cfg_wdata <= {16'($urandom), cols};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_GRID_ROWS;
        i_cfg_wdata <= {16'($urandom), rows};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_INV_CELL;
        i_cfg_wdata <= inv;
        @(posedge i_clk);
        if (touch_unused) begin
            i_cfg_addr  <= CFG_UNUSED;
            i_cfg_wdata <= CFG_DATA_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cur_cols = (cols < 2) ? 2 : (cols > MAX_SIDE) ? MAX_SIDE : int'(cols);
        cur_rows = (rows < 2) ? 2 : (rows > MAX_SIDE) ? MAX_SIDE : int'(rows);
        cur_inv  = longint'(inv);
    endtask

    // Pick a world coordinate that lands near the grid along one axis; z runs toward
    // lower rows, so its mapping is mirrored.
    function automatic logic [POS_W-1:0] aim_position(input int side, input bit mirrored);
        longint      half, target, p;
        int unsigned span;
        half   = longint'(side - 1) << (FRAC_W - 1);
        span   = 32'(side + 3) << FRAC_W;
        target = longint'($urandom_range(0, span)) - (longint'(2) << FRAC_W);
        if (chance(15)) target = target & ~((longint'(1) << FRAC_W) - 1);
        if (cur_inv == 0) begin
            p = longint'($signed(POS_W'($urandom)));
        end else begin
            p = (target - half) / cur_inv;
            if (mirrored) p = -p;
        end
        if (p > (longint'(1) << (POS_W - 1)) - 1) p = (longint'(1) << (POS_W - 1)) - 1;
        if (p < -(longint'(1) << (POS_W - 1))) p = -(longint'(1) << (POS_W - 1));
        return POS_W'(p);
    endfunction

    // One random transaction: mostly queries aimed at the grid, some vertex writes.
    task automatic random_item();
        int                  pick;
        logic [VIDX_W-1:0]   vidx;
        logic [HEIGHT_W-1:0] vh;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            vidx = chance(90) ? VIDX_W'($urandom_range(0, STORE_DEPTH - 1))
                              : VIDX_W'($urandom);
            vh = chance(10) ? (chance(50) ? 16'h8000 : 16'h7FFF) : HEIGHT_W'($urandom);
            send_item(MODE_WRITE, POS_W'($urandom), POS_W'($urandom), vidx, vh);
        end else if (pick < 88) begin
            send_query(aim_position(cur_cols, 1'b0), aim_position(cur_rows, 1'b1));
        end else begin
            send_query(POS_W'($urandom), POS_W'($urandom));
        end
    endtask

    initial begin : stimulus
        logic [CFG_SIDE_W-1:0] cols;
        logic [CFG_SIDE_W-1:0] rows;
        logic [INV_W-1:0]      inv;
        bit                    touch_unused;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every vertex so that no query can read an unwritten entry.
        for (int v = 0; v < STORE_DEPTH; v++) begin
            send_item(MODE_WRITE, POS_W'($urandom), POS_W'($urandom), VIDX_W'(v),
                      HEIGHT_W'($urandom));
        end

        // Directed part on the reset grid: 129 x 129, one cell per 256 position units.
        send_item(MODE_WRITE, '0, '0, VIDX_W'(0), 16'h8000);
        send_item(MODE_WRITE, '0, '0, VIDX_W'(STORE_DEPTH - 1), 16'h7FFF);
        send_item(MODE_WRITE, '0, '0, VIDX_W'(1), 16'h7FFF);
        send_item(MODE_WRITE, '0, '0, VIDX_W'(MAX_SIDE), 16'h7FFF);
        send_item(MODE_WRITE, '0, '0, VIDX_W'(MAX_SIDE + 1), 16'h8000);
        // Writes past the end of the store are dropped.
        send_item(MODE_WRITE, '1, '1, VIDX_W'(STORE_DEPTH), 16'h1234);
        send_item(MODE_WRITE, '1, '1, '1, '1);
        // Grid centre, two opposite corners exactly, and just past the right and left edges.
        send_query(POS_W'(0), POS_W'(0));
        send_query(POS_W'(-64 * 256), POS_W'(64 * 256));
        send_query(POS_W'(64 * 256), POS_W'(-64 * 256));
        send_query(POS_W'(64 * 256 + 1), POS_W'(0));
        send_query(POS_W'(-64 * 256 - 1), POS_W'(0));
        // Positions at the extremes of the field, far outside the grid.
        send_query(24'h800000, 24'h800000);
        send_query(24'h7FFFFF, 24'h7FFFFF);
        send_query(24'h800000, 24'h7FFFFF);
        // Inside the corner cell: on the diagonal, below it, and near each of its two far edges.
        send_query(POS_W'(-64 * 256 + 128), POS_W'(64 * 256 - 128));
        send_query(POS_W'(-64 * 256 + 64), POS_W'(64 * 256 - 64));
        send_query(POS_W'(-64 * 256 + 255), POS_W'(64 * 256 - 1));
        send_query(POS_W'(-64 * 256 + 1), POS_W'(64 * 256 - 255));
        wait_idle();

        // Random phases over several grid settings and idling profiles.
        for (int ph = 0; ph < PHASES; ph++) begin
            touch_unused = 1'b0;
            case (ph)
                0: begin cols = 8'd2;   rows = 8'd2;   inv = 24'd65536;    end
                1: begin cols = 8'd129; rows = 8'd129; inv = 24'hFFFFFF;   end
                2: begin
                    cols = 8'd0; rows = 8'd255; inv = 24'd1; touch_unused = 1'b1;
                end
                3: begin
                    cols = 8'd17; rows = 8'd5; inv = INV_W'($urandom_range(1, 1 << 20));
                end
                // Zero reciprocal: every position lands on the grid centre.
                4: begin cols = 8'd255; rows = 8'd0;   inv = 24'd0;        end
                default: begin
                    cols = CFG_SIDE_W'($urandom);
                    rows = CFG_SIDE_W'($urandom);
                    inv  = INV_W'($urandom_range(1, (1 << INV_W) - 1));
                end
            endcase
            if (ph < 2) begin
                tx_idle_pct = 37;
                rx_idle_pct = 46;
            end else if (ph < 4) begin
                tx_idle_pct = 46;
                rx_idle_pct = 37;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            program_grid(cols, rows, inv, touch_unused);
            repeat (ITEMS_PER_PHASE) random_item();
            wait_idle();
        end

        $display("Run covered %0d input transactions, %0d height queries (%0d off the grid),",
                 item_count, query_count, clamp_count);
        $display("over the reset grid and %0d programmed grid settings.", PHASES);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: a correct run ends far earlier.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- heightfield_height_query.f -----
+incdir+design
design/hfq_pkg.sv
design/hfq_ram.sv
design/heightfield_height_query.sv
sim/heightfield_height_query_checker.sv
sim/heightfield_height_query_tb.sv
